[rtl/kcg_pkg.sv]
// Shared types, widths and codes of the k-combination generator.
package kcg_pkg;

  localparam int unsigned MAX_ITEMS  = 16;
  localparam int unsigned MAX_CHOOSE = 8;
  localparam int unsigned VALUE_BITS = 16;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned POS_W      = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W      = $clog2(MAX_CHOOSE);
  localparam int unsigned NCNT_W     = 5;
  localparam int unsigned KCNT_W     = 4;
  localparam int unsigned LIM_W      = NCNT_W + 1;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [NCNT_W-1:0] ITEM_COUNT_RESET   = NCNT_W'(16);
  localparam logic [KCNT_W-1:0] CHOOSE_COUNT_RESET = KCNT_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_NEXT    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITEM_COUNT   = 2'd0,
    CFG_CHOOSE_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FILL,
    ST_EMIT_RD,
    ST_EMIT_ST,
    ST_EMIT_LD,
    ST_EXH
  } state_e;

  // Effective enumeration settings plus a rewind strobe from the register file.
  typedef struct packed {
    logic [NCNT_W-1:0] n;
    logic [KCNT_W-1:0] k;
    logic              rewind;
  } cfg_t;

endpackage

[rtl/kcg_ram.sv]
// Simple dual-port synchronous RAM with one write and one registered read port.
module kcg_ram #(
  parameter int unsigned DEPTH = kcg_pkg::MAX_ITEMS,
  parameter int unsigned WIDTH = kcg_pkg::VALUE_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kcg_seq.sv]
// Sequencer: walks the position memory, advances the combination and emits results.
module kcg_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kcg_pkg::cfg_t                     cfg_i,
  input  logic                              cfg_valid_i,
  output logic                              idle_o,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kcg_pkg::KIND_W-1:0]        kind_i,
  input  logic [kcg_pkg::IDX_W-1:0]         index_i,
  input  logic [kcg_pkg::VALUE_BITS-1:0]    value_i,
  output logic                              st_we_o,
  output logic [kcg_pkg::POS_W-1:0]         st_waddr_o,
  output logic [kcg_pkg::VALUE_BITS-1:0]    st_wdata_o,
  output logic [kcg_pkg::POS_W-1:0]         st_raddr_o,
  input  logic [kcg_pkg::VALUE_BITS-1:0]    st_rdata_i,
  output logic                              pos_we_o,
  output logic [kcg_pkg::CNT_W-1:0]         pos_waddr_o,
  output logic [kcg_pkg::POS_W-1:0]         pos_wdata_o,
  output logic [kcg_pkg::CNT_W-1:0]         pos_raddr_o,
  input  logic [kcg_pkg::POS_W-1:0]         pos_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kcg_pkg::VALUE_BITS-1:0]    element_value_o,
  output logic [kcg_pkg::SLOT_W-1:0]        slot_o,
  output logic                              last_o,
  output logic                              exhausted_o
);

  kcg_pkg::state_e                 state_q, state_d;
  logic [kcg_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [kcg_pkg::POS_W-1:0]       val_q, val_d;
  logic                            started_q, started_d;
  logic                            finished_q, finished_d;
  logic                            out_valid_q;
  logic [kcg_pkg::VALUE_BITS-1:0]  out_value_q;
  logic [kcg_pkg::SLOT_W-1:0]      out_slot_q;
  logic                            out_last_q;
  logic                            out_exh_q;

  logic                            in_acc;
  logic                            is_next;
  logic                            exh_cond;
  logic [kcg_pkg::KCNT_W-1:0]      k_m1;
  logic [kcg_pkg::CNT_W-1:0]       k_last;
  logic                            cnt_is_last;
  logic [kcg_pkg::LIM_W-1:0]       limit;
  logic                            can_adv;
  logic                            out_free;
  logic                            out_load;
  logic                            out_load_exh;

  assign in_stall_o  = (state_q != kcg_pkg::ST_IDLE) || cfg_valid_i;
  assign idle_o      = (state_q == kcg_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_next     = (kind_i == kcg_pkg::KIND_NEXT);
  assign exh_cond    = finished_q || (cfg_i.k == '0) || (cfg_i.n == '0) ||
                       ({1'b0, cfg_i.k} > cfg_i.n);
  assign k_m1        = cfg_i.k - kcg_pkg::KCNT_W'(1);
  assign k_last      = k_m1[kcg_pkg::CNT_W-1:0];
  assign cnt_is_last = (cnt_q == k_last);
  // Highest value slot p may take: n - k + p.
  assign limit       = kcg_pkg::LIM_W'(cfg_i.n) - kcg_pkg::LIM_W'(cfg_i.k) +
                       kcg_pkg::LIM_W'(cnt_q);
  assign can_adv     = (kcg_pkg::LIM_W'(pos_rdata_i) < limit);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kcg_pkg::ST_IDLE: begin
        if (in_acc && is_next) begin
          if (exh_cond) begin
            state_d = kcg_pkg::ST_EXH;
          end else if (!started_q) begin
            state_d = kcg_pkg::ST_INIT;
          end else begin
            state_d = kcg_pkg::ST_SCAN_RD;
          end
        end
      end
      kcg_pkg::ST_INIT: begin
        if (cnt_is_last) state_d = kcg_pkg::ST_EMIT_RD;
      end
      kcg_pkg::ST_SCAN_RD:  state_d = kcg_pkg::ST_SCAN_CMP;
      kcg_pkg::ST_SCAN_CMP: begin
        if (can_adv) begin
          state_d = kcg_pkg::ST_FILL;
        end else if (cnt_q == '0) begin
          state_d = kcg_pkg::ST_EXH;
        end else begin
          state_d = kcg_pkg::ST_SCAN_RD;
        end
      end
      kcg_pkg::ST_FILL: begin
        if (cnt_is_last) state_d = kcg_pkg::ST_EMIT_RD;
      end
      kcg_pkg::ST_EMIT_RD: state_d = kcg_pkg::ST_EMIT_ST;
      kcg_pkg::ST_EMIT_ST: state_d = kcg_pkg::ST_EMIT_LD;
      kcg_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          state_d = cnt_is_last ? kcg_pkg::ST_IDLE : kcg_pkg::ST_EMIT_RD;
        end
      end
      kcg_pkg::ST_EXH: begin
        if (out_free) state_d = kcg_pkg::ST_IDLE;
      end
      default: state_d = kcg_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and memory ports.
  always_comb begin
    cnt_d        = cnt_q;
    val_d        = val_q;
    started_d    = started_q;
    finished_d   = finished_q;
    st_we_o      = 1'b0;
    st_waddr_o   = index_i;
    st_wdata_o   = value_i;
    st_raddr_o   = pos_rdata_i;
    pos_we_o     = 1'b0;
    pos_waddr_o  = cnt_q;
    pos_wdata_o  = val_q;
    pos_raddr_o  = cnt_q;
    out_load     = 1'b0;
    out_load_exh = 1'b0;

    if (cfg_i.rewind) begin
      started_d  = 1'b0;
      finished_d = 1'b0;
    end

    unique case (state_q)
      kcg_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (kcg_pkg::kind_e'(kind_i))
            kcg_pkg::KIND_LOAD: st_we_o = 1'b1;
            kcg_pkg::KIND_RESTART: begin
              started_d  = 1'b0;
              finished_d = 1'b0;
            end
            kcg_pkg::KIND_NEXT: begin
              if (!exh_cond) begin
                if (!started_q) begin
                  started_d = 1'b1;
                  cnt_d     = '0;
                end else begin
                  cnt_d = k_last;
                end
              end
            end
            default: ;
          endcase
        end
      end
      kcg_pkg::ST_INIT: begin
        pos_we_o    = 1'b1;
        pos_wdata_o = kcg_pkg::POS_W'(cnt_q);
        cnt_d       = cnt_is_last ? '0 : cnt_q + 1'b1;
      end
      kcg_pkg::ST_SCAN_RD: ;
      kcg_pkg::ST_SCAN_CMP: begin
        if (can_adv) begin
          val_d = pos_rdata_i + 1'b1;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      kcg_pkg::ST_FILL: begin
        pos_we_o = 1'b1;
        val_d    = val_q + 1'b1;
        cnt_d    = cnt_is_last ? '0 : cnt_q + 1'b1;
      end
      kcg_pkg::ST_EMIT_RD: ;
      kcg_pkg::ST_EMIT_ST: ;
      kcg_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          cnt_d    = cnt_is_last ? '0 : cnt_q + 1'b1;
        end
      end
      kcg_pkg::ST_EXH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_load_exh = 1'b1;
          finished_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kcg_pkg::ST_IDLE;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      started_q  <= started_d;
      finished_q <= finished_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (out_load) begin
      out_value_q <= out_load_exh ? '0 : st_rdata_i;
      out_slot_q  <= out_load_exh ? '0 : kcg_pkg::SLOT_W'(cnt_q);
      out_last_q  <= out_load_exh ? 1'b1 : cnt_is_last;
      out_exh_q   <= out_load_exh;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_value_o = out_value_q;
  assign slot_o          = out_slot_q;
  assign last_o          = out_last_q;
  assign exhausted_o     = out_exh_q;

endmodule

[rtl/k_combination_generator.sv]
// Top level of the lexicographic k-combination generator.
// Load and restart transactions complete in their accepting cycle. A next transaction seeds
// the first combination, or scans back from the last slot and rewrites the slots from the
// advanced one on; it then emits each slot (held under output stalls) or an exhausted marker.
// One transaction is in flight at a time; the result register lets a new one start meanwhile.
// Reset (async, active low) clears control state and sets item_count 16, choose_count 2.
module k_combination_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kcg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [kcg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kcg_pkg::KIND_W-1:0]        kind_i,
  input  logic [kcg_pkg::IDX_W-1:0]         index_i,
  input  logic [kcg_pkg::VALUE_BITS-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kcg_pkg::VALUE_BITS-1:0]    element_value_o,
  output logic [kcg_pkg::SLOT_W-1:0]        slot_o,
  output logic                              last_o,
  output logic                              exhausted_o
);

  // Configuration registers. A write to either register also rewinds the
  // enumeration, just like a restart transaction.
  logic [kcg_pkg::NCNT_W-1:0] item_count_q;
  logic [kcg_pkg::KCNT_W-1:0] choose_count_q;
  logic                       cfg_we;
  logic                       cfg_hit;
  logic                       idle;
  kcg_pkg::cfg_t              cfg;

  assign cfg_ready_o = idle;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = (cfg_index_i == kcg_pkg::CFG_ITEM_COUNT) ||
                       (cfg_index_i == kcg_pkg::CFG_CHOOSE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q   <= kcg_pkg::ITEM_COUNT_RESET;
      choose_count_q <= kcg_pkg::CHOOSE_COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index_i == kcg_pkg::CFG_ITEM_COUNT) begin
        item_count_q <= cfg_data_i;
      end else if (cfg_index_i == kcg_pkg::CFG_CHOOSE_COUNT) begin
        choose_count_q <= cfg_data_i[kcg_pkg::KCNT_W-1:0];
      end
    end
  end

  // Values above the store size or the slot count saturate.
  always_comb begin
    cfg.n      = (item_count_q > kcg_pkg::NCNT_W'(kcg_pkg::MAX_ITEMS)) ?
                 kcg_pkg::NCNT_W'(kcg_pkg::MAX_ITEMS) : item_count_q;
    cfg.k      = (choose_count_q > kcg_pkg::KCNT_W'(kcg_pkg::MAX_CHOOSE)) ?
                 kcg_pkg::KCNT_W'(kcg_pkg::MAX_CHOOSE) : choose_count_q;
    cfg.rewind = cfg_we && cfg_hit;
  end

  // Element store and chosen-position memory. The sequencer only writes the
  // store while idle and always finishes a position write before it reads that
  // entry back, so no forwarding path is needed. The position memory is seeded
  // by the first next transaction after a rewind, so it needs no reset.
  logic                              st_we;
  logic [kcg_pkg::POS_W-1:0]         st_waddr;
  logic [kcg_pkg::VALUE_BITS-1:0]    st_wdata;
  logic [kcg_pkg::POS_W-1:0]         st_raddr;
  logic [kcg_pkg::VALUE_BITS-1:0]    st_rdata;
  logic                              pos_we;
  logic [kcg_pkg::CNT_W-1:0]         pos_waddr;
  logic [kcg_pkg::POS_W-1:0]         pos_wdata;
  logic [kcg_pkg::CNT_W-1:0]         pos_raddr;
  logic [kcg_pkg::POS_W-1:0]         pos_rdata;

  kcg_ram #(
    .DEPTH(kcg_pkg::MAX_ITEMS),
    .WIDTH(kcg_pkg::VALUE_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  kcg_ram #(
    .DEPTH(kcg_pkg::MAX_CHOOSE),
    .WIDTH(kcg_pkg::POS_W)
  ) u_pos (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  kcg_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cfg_valid_i    (cfg_valid_i),
    .idle_o         (idle),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .st_raddr_o     (st_raddr),
    .st_rdata_i     (st_rdata),
    .pos_we_o       (pos_we),
    .pos_waddr_o    (pos_waddr),
    .pos_wdata_o    (pos_wdata),
    .pos_raddr_o    (pos_raddr),
    .pos_rdata_i    (pos_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .element_value_o(element_value_o),
    .slot_o         (slot_o),
    .last_o         (last_o),
    .exhausted_o    (exhausted_o)
  );

  // An exhausted result is a lone, final result at slot zero.
  a_exh_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> last_o && (slot_o == '0) && (element_value_o == '0))
    else $error("exhausted result not a single final slot-zero result");

  // Once a non-final slot is taken, the run continues and cannot turn into exhausted.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !exhausted_o && !last_o |=> !(out_valid_o && exhausted_o))
    else $error("exhausted result inside a combination run");

  // A next transaction always keeps the sequencer busy for the following cycle.
  a_next_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == kcg_pkg::KIND_NEXT) |=> in_stall_o)
    else $error("sequencer idle right after a next transaction");

endmodule

[dv/k_combination_generator_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the k-combination generator with its own enumeration predictor.
module k_combination_generator_test;
  import kcg_pkg::*;

  // Kind code that the block must ignore, and a register index with no register behind it.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // The settling time lets a next transaction finish, with ample slack, before config writes.
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 30;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [IDX_W-1:0]      index;
    logic [VALUE_BITS-1:0] value;
  } gen_cmd_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] element_value;
    logic [SLOT_W-1:0]     slot;
    logic                  last;
    logic                  exhausted;
  } slot_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = CFG_ITEM_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i          = KIND_LOAD;
  logic [IDX_W-1:0]      index_i         = '0;
  logic [VALUE_BITS-1:0] value_i         = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [VALUE_BITS-1:0] element_value_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  last_o;
  logic                  exhausted_o;

  k_combination_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .element_value_o(element_value_o),
    .slot_o         (slot_o),
    .last_o         (last_o),
    .exhausted_o    (exhausted_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Enumeration predictor. It mirrors the block's architectural state: the element store, the
  // chosen positions of the current combination, the started/finished flags and both registers.
  // ---------------------------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] store_copy [MAX_ITEMS];
  int                    chosen_pos [MAX_CHOOSE];
  bit                    enum_started;
  bit                    enum_finished;
  logic [NCNT_W-1:0]     item_count_reg   = ITEM_COUNT_RESET;
  logic [KCNT_W-1:0]     choose_count_reg = CHOOSE_COUNT_RESET;

  slot_result_t expected_slots [$];
  gen_cmd_t     pending_cmds [$];

  int unsigned errors         = 0;
  int unsigned cmds_taken     = 0;
  int unsigned slots_seen     = 0;
  int unsigned exhausted_seen = 0;
  int unsigned combos_seen    = 0;
  int unsigned cfg_writes     = 0;

  // Idle percentages of the sender and the receiver; the stimulus changes them per phase.
  int unsigned src_idle_pct = 36;
  int unsigned snk_idle_pct = 36;
  bit          hold_request = 1'b0;

  // Steps to the lexicographically next set of positions; false once the last set was reached.
  function automatic bit advance_positions(int n, int k);
    for (int p = k - 1; p >= 0; p--) begin
      if (chosen_pos[p] < n - k + p) begin
        chosen_pos[p]++;
        for (int j = p + 1; j < k; j++) chosen_pos[j] = chosen_pos[j-1] + 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted command and queues the slot results it must produce.
  function automatic void enumerate_step(gen_cmd_t cmd);
    int           n;
    int           k;
    bit           have_combo;
    slot_result_t res;
    // Register values above the store or combination size saturate.
    n = (item_count_reg > MAX_ITEMS) ? MAX_ITEMS : int'(item_count_reg);
    k = (choose_count_reg > MAX_CHOOSE) ? MAX_CHOOSE : int'(choose_count_reg);
    if (cmd.kind == KIND_LOAD) begin
      store_copy[cmd.index] = cmd.value;
    end else if (cmd.kind == KIND_RESTART) begin
      enum_started  = 1'b0;
      enum_finished = 1'b0;
    end else if (cmd.kind == KIND_NEXT) begin
      have_combo = !(enum_finished || k == 0 || n == 0 || k > n);
      if (have_combo && !enum_started) begin
        for (int s = 0; s < k; s++) chosen_pos[s] = s;
        enum_started = 1'b1;
      end else if (have_combo) begin
        have_combo = advance_positions(n, k);
      end
      if (!have_combo) begin
        // The exhausted marker repeats on every next command until a rewind.
        enum_finished     = 1'b1;
        res.element_value = '0;
        res.slot          = '0;
        res.last          = 1'b1;
        res.exhausted     = 1'b1;
        expected_slots.push_back(res);
      end else begin
        for (int s = 0; s < k; s++) begin
          res.element_value = store_copy[chosen_pos[s]];
          res.slot          = SLOT_W'(s);
          res.last          = (s + 1 == k);
          res.exhausted     = 1'b0;
          expected_slots.push_back(res);
        end
      end
    end
    // Any other kind is ignored by the block.
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Command driver. A transaction is accepted at an edge where valid is high and stall is low.
  // The payload is held while stalled; otherwise the next pending command is offered unless the
  // sender decides to idle this cycle. Each signal gets a single nonblocking write per edge.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    gen_cmd_t cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_LOAD;
      index_i    <= '0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cmd.kind  = kind_i;
        cmd.index = index_i;
        cmd.value = value_i;
        enumerate_step(cmd);
        cmds_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cmd = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= cmd.kind;
          index_i    <= cmd.index;
          value_i    <= cmd.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result receiver. It stalls at random, and once on request holds off for a long stretch so
  // that the block fills up and pushes back on the command channel.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < snk_idle_pct);
    end
  end

  // Result monitor: every accepted result transaction is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    slot_result_t got;
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.element_value = element_value_o;
      got.slot          = slot_o;
      got.last          = last_o;
      got.exhausted     = exhausted_o;
      slots_seen++;
      if (exhausted_o) exhausted_seen++;
      else if (last_o) combos_seen++;
      if (expected_slots.size() == 0) begin
        note_failure($sformatf("unexpected result: value %h slot %0d last %0b exhausted %0b",
                               got.element_value, got.slot, got.last, got.exhausted));
      end else begin
        want = expected_slots.pop_front();
        if (got.element_value !== want.element_value || got.slot !== want.slot ||
            got.last !== want.last || got.exhausted !== want.exhausted) begin
          note_failure($sformatf({"result mismatch: expected value %h slot %0d last %0b ",
                                  "exhausted %0b, got value %h slot %0d last %0b exhausted %0b"},
                                 want.element_value, want.slot, want.last, want.exhausted,
                                 got.element_value, got.slot, got.last, got.exhausted));
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind has been accepted for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction", quiet);
        $display("k_combination_generator test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------------
  task automatic queue_cmd(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                           logic [VALUE_BITS-1:0] value);
    gen_cmd_t cmd;
    cmd.kind  = kind;
    cmd.index = index;
    cmd.value = value;
    pending_cmds.push_back(cmd);
  endtask

  // Waits until every command is in, every result is out and the block has had time to finish
  // any command that produces no result.
  task automatic settle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_slots.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write. Only issued while the block is idle; any write to a real register rewinds
  // the enumeration exactly as a restart command does.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == CFG_ITEM_COUNT) begin
      item_count_reg = data[NCNT_W-1:0];
      enum_started   = 1'b0;
      enum_finished  = 1'b0;
    end else if (idx == CFG_CHOOSE_COUNT) begin
      choose_count_reg = data[KCNT_W-1:0];
      enum_started     = 1'b0;
      enum_finished    = 1'b0;
    end
  endtask

  task automatic set_sizes(int unsigned n, int unsigned k);
    write_reg(CFG_ITEM_COUNT, CFG_DATA_W'(n));
    write_reg(CFG_CHOOSE_COUNT, CFG_DATA_W'(k));
  endtask

  task automatic queue_nexts(int unsigned count);
    repeat (count) queue_cmd(KIND_NEXT, IDX_W'($urandom), VALUE_BITS'($urandom));
  endtask

  // Random commands: mostly next commands, so small enumerations run to their end, mixed with
  // loads that rewrite elements, restarts that rewind, and ignored kinds as noise.
  task automatic queue_random_mix(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      queue_cmd(KIND_NEXT, IDX_W'($urandom), VALUE_BITS'($urandom));
      else if (pick < 85) queue_cmd(KIND_LOAD, IDX_W'($urandom), VALUE_BITS'($urandom));
      else if (pick < 93) queue_cmd(KIND_RESTART, IDX_W'($urandom), VALUE_BITS'($urandom));
      else                queue_cmd(KIND_UNUSED, IDX_W'($urandom), VALUE_BITS'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    int unsigned k;
    for (int i = 0; i < MAX_ITEMS; i++) store_copy[i] = '0;
    for (int i = 0; i < MAX_CHOOSE; i++) chosen_pos[i] = 0;
    enum_started  = 1'b0;
    enum_finished = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every store entry is written before any combination can read it. The first entries carry
    // all-zero, all-one and alternating patterns. Reset sizes are 16 items, 2 chosen.
    queue_cmd(KIND_LOAD, 4'd0, 16'h0000);
    queue_cmd(KIND_LOAD, 4'd1, 16'hFFFF);
    queue_cmd(KIND_LOAD, 4'd2, 16'h5555);
    queue_cmd(KIND_LOAD, 4'd3, 16'hAAAA);
    for (int i = 4; i < MAX_ITEMS; i++) queue_cmd(KIND_LOAD, IDX_W'(i), VALUE_BITS'($urandom));
    queue_nexts(3);
    queue_cmd(KIND_RESTART, 4'd0, 16'h0000);
    queue_nexts(1);
    queue_cmd(KIND_UNUSED, 4'hF, 16'hFFFF);
    queue_nexts(1);
    settle();

    // Choose equal to the item count: one combination, then repeated exhausted markers, and a
    // restart that brings the single combination back.
    set_sizes(3, 3);
    queue_nexts(3);
    queue_cmd(KIND_RESTART, 4'd0, 16'h0000);
    queue_nexts(1);
    settle();

    // A register write in the middle of an enumeration rewinds it; a write to an index with no
    // register behind it must leave the enumeration where it is.
    write_reg(CFG_CHOOSE_COUNT, 5'd2);
    queue_nexts(1);
    settle();
    write_reg(CFG_UNUSED, 5'd31);
    queue_nexts(3);
    settle();

    // Choose larger than the item count, then zero items and zero choose.
    set_sizes(3, 4);
    queue_nexts(2);
    settle();
    set_sizes(0, 2);
    queue_nexts(2);
    settle();
    set_sizes(5, 0);
    queue_nexts(2);
    settle();

    // Smallest enumeration, and register values above their limits (saturate at 16 and 8).
    set_sizes(1, 1);
    queue_nexts(2);
    settle();
    set_sizes(31, 15);
    queue_nexts(3);
    settle();
    write_reg(CFG_CHOOSE_COUNT, 5'd31);
    queue_nexts(1);
    settle();
    set_sizes(16, 1);
    queue_nexts(17);
    settle();

    // Random phases over random sizes, mostly small so that enumerations reach exhaustion.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 7) : $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 85)
        k = $urandom_range(1, (n == 0) ? 1 : ((n > MAX_CHOOSE) ? MAX_CHOOSE : n));
      else
        k = $urandom_range(0, 15);
      // One phase runs with no idling on either side.
      src_idle_pct = (ph == 3) ? 0 : 36;
      snk_idle_pct = (ph == 3) ? 0 : 36;
      set_sizes(n, k);
      queue_random_mix(PHASE_ITEMS);
      settle();
    end
    src_idle_pct = 36;
    snk_idle_pct = 36;

    // Back-pressure: the receiver holds off for a long stretch while the sender keeps offering
    // next commands with the widest combinations.
    set_sizes(16, 8);
    src_idle_pct = 0;
    queue_nexts(20);
    @(posedge clk_i);
    hold_request <= 1'b1;
    settle();
    src_idle_pct = 36;

    if (expected_slots.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_slots.size()));

    $display("Covered %0d commands and %0d register writes; checked %0d result slots,",
             cmds_taken, cfg_writes, slots_seen);
    $display("  %0d complete combinations and %0d exhausted markers, %0d errors.",
             combos_seen, exhausted_seen, errors);
    if (errors == 0) begin
      $display("k_combination_generator test passed");
    end else begin
      $display("k_combination_generator test failed");
    end
    $finish;
  end

endmodule
